/* rtl/ac97_bus_master_register_file_top_defines.svh */
// Assertion macros for the bus-master register file.
`ifndef AC97_BUS_MASTER_REGISTER_FILE_TOP_DEFINES_SVH
`define AC97_BUS_MASTER_REGISTER_FILE_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define AC97BM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ac97bm: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define AC97BM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ac97bm: next-cycle check failed");

`endif

/* rtl/ac97bm_pkg.sv */
// Package: item types, register map constants and reset values of the register file.
`timescale 1ns / 1ps
package ac97bm_pkg;

  localparam int REG_BYTES = 4096;
  localparam int ADDR_W    = $clog2(REG_BYTES);

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam int CH_COUNT = 4;
  localparam logic [11:0] CH_BASE [CH_COUNT] = '{12'h100, 12'h110, 12'h120, 12'h170};
  localparam logic [11:0] CH_STAT_OFS    = 12'd6;
  localparam logic [11:0] CH_CTL_OFS     = 12'd11;
  localparam logic [11:0] CH_CTL_TO_STAT = 12'd5;
  localparam logic [3:0]  CH_STAT_IDX    = 4'd6;
  localparam logic [3:0]  CH_LAST_IDX    = 4'd11;

  localparam logic [11:0] GLOBAL_STATUS = 12'h130;
  localparam logic [11:0] CODEC_READY   = 12'h131;

  localparam logic [7:0] CTL_MASK  = 8'h1F;
  localparam logic [7:0] CTL_KEEP  = 8'h1C;
  localparam logic [7:0] STAT_W1C  = 8'h1C;
  localparam logic [7:0] STAT_HALT = 8'h01;
  localparam int         CTL_RUN_BIT   = 0;
  localparam int         CTL_RESET_BIT = 1;

  typedef struct packed {
    logic        opcode;
    logic [11:0] byte_address;
    logic [3:0]  access_bytes;
    logic [63:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        access_error;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Power-up content of one byte: codec ready and every channel status read as 1.
  function automatic logic [7:0] reset_value(input logic [ADDR_W-1:0] a);
    logic hit;
    hit = (a == ADDR_W'(CODEC_READY));
    for (int i = 0; i < CH_COUNT; i++) begin
      if (a == ADDR_W'(CH_BASE[i] + CH_STAT_OFS)) begin
        hit = 1'b1;
      end
    end
    return hit ? 8'h01 : 8'h00;
  endfunction

endpackage

/* rtl/ac97bm_ram.sv */
// Byte-wide register store: one write port and one registered read port.
`timescale 1ns / 1ps
module ac97bm_ram
  import ac97bm_pkg::*;
(
  input  logic       clk,
  input  ram_req_t   req,
  output logic [7:0] rd_q
);

  logic [7:0] mem_r [REG_BYTES];
  logic [7:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_q_r <= mem_r[req.raddr];
    end
  end

  assign rd_q = rd_q_r;

endmodule

/* rtl/ac97_bus_master_register_file_top.sv */
// Top level: byte-serial sequencer over the AC'97 bus-master register store.
//
//  channel | direction | handshake            | beat payload
//  --------+-----------+----------------------+------------------------------------------
//  in_     | input     | in_valid / in_stall   | opcode, byte_address, access_bytes, data
//  out_    | output    | out_valid / out_stall | read_data, access_error
//
// Every byte goes through the byte-wide store, one byte a cycle. A status or run/stop
// write rewrites the status byte, a channel reset sweeps the channel, and a rejected
// beat or a global status dword write goes straight to the finish state. After reset
// a pass loads the power-up value into all REG_BYTES bytes with in_stall high. One
// beat is taken at a time; a finished result sits in the output register, and a
// stalled output holds the next result in the finish state.
`timescale 1ns / 1ps
`include "ac97_bus_master_register_file_top_defines.svh"
module ac97_bus_master_register_file_top
  import ac97bm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_SWEEP,
    ST_FIN
  } state_t;

  // Flavor of a read-modify-write on a channel register.
  typedef enum logic [1:0] {
    K_STAT,
    K_CTL_RUN,
    K_CTL_RST
  } kind_t;

  state_t            state_r;
  kind_t             kind_r;
  logic [ADDR_W-1:0] clr_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] tgt_r;
  logic [3:0]        size_r;
  logic [3:0]        cnt_r;
  logic [63:0]       wdata_r;
  logic [63:0]       rdata_r;
  logic              err_r;
  logic              out_valid_r;
  out_item_t         out_r;

  ram_req_t   ram_req;
  logic [7:0] ram_q;

  logic        in_fire;
  logic        in_err;
  logic [12:0] end_addr;
  logic        ctl_hit;
  logic        stat_hit;
  logic        glob_hit;
  logic        ctl_run;
  logic [7:0]  low_byte;
  logic [2:0]  cap_idx;
  logic        out_free;

  ac97bm_ram u_ram (
    .clk  (clk),
    .req  (ram_req),
    .rd_q (ram_q)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign low_byte  = in_data.write_data[7:0];
  assign cap_idx   = 3'(cnt_r - 4'd1);

  // Reject zero or oversize accesses and any that runs past the end of the space.
  assign end_addr = {1'b0, in_data.byte_address} + {9'd0, in_data.access_bytes};
  assign in_err   = (in_data.access_bytes == 4'd0) || (in_data.access_bytes > 4'd8) ||
                    (end_addr > 13'(REG_BYTES));

  // Run/stop write: status first, then the masked control byte as a one-byte write.
  assign ctl_run = (in_data.opcode == OP_WRITE) && ctl_hit && !low_byte[CTL_RESET_BIT];

  // Decode the channel control and status bytes and the global status dword; no two overlap.
  always_comb begin
    ctl_hit  = 1'b0;
    stat_hit = 1'b0;
    for (int i = 0; i < CH_COUNT; i++) begin
      if (in_data.byte_address == CH_BASE[i] + CH_CTL_OFS &&
          in_data.access_bytes == 4'd1) begin
        ctl_hit = 1'b1;
      end
      if (in_data.byte_address == CH_BASE[i] + CH_STAT_OFS &&
          (in_data.access_bytes == 4'd1 || in_data.access_bytes == 4'd2)) begin
        stat_hit = 1'b1;
      end
    end
    glob_hit = (in_data.byte_address == GLOBAL_STATUS) && (in_data.access_bytes == 4'd4);
  end

  // Store port requests for each sequencer step.
  always_comb begin
    ram_req = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_r;
        ram_req.wdata = reset_value(clr_r);
      end
      ST_READ: begin
        ram_req.re    = (cnt_r < size_r);
        ram_req.raddr = addr_r + ADDR_W'(cnt_r);
      end
      ST_WRITE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = addr_r + ADDR_W'(cnt_r);
        ram_req.wdata = wdata_r[{cnt_r[2:0], 3'b000} +: 8];
      end
      ST_RMW_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = (kind_r == K_CTL_RST) ? addr_r : tgt_r;
      end
      ST_RMW_WR: begin
        ram_req.we    = (kind_r != K_CTL_RST);
        ram_req.waddr = tgt_r;
        if (kind_r == K_STAT) begin
          ram_req.wdata = ram_q & ~(wdata_r[7:0] & STAT_W1C);
        end else begin
          // Run clears halted, stop sets it.
          ram_req.wdata = wdata_r[CTL_RUN_BIT] ? (ram_q & ~STAT_HALT) : (ram_q | STAT_HALT);
        end
      end
      ST_SWEEP: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = tgt_r + ADDR_W'(cnt_r);
        if (cnt_r == CH_STAT_IDX) begin
          ram_req.wdata = STAT_HALT;
        end else if (cnt_r == CH_LAST_IDX) begin
          // The old control byte still sits in the read register.
          ram_req.wdata = ram_q & CTL_KEEP;
        end else begin
          ram_req.wdata = 8'h00;
        end
      end
      default: begin
        ram_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop a taken result unless the finish step loads the next one.
      if (out_valid_r && !out_stall && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + ADDR_W'(1);
          if (clr_r == ADDR_W'(REG_BYTES - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            rdata_r <= '0;
            err_r   <= in_err;
            cnt_r   <= '0;
            addr_r  <= ADDR_W'(in_data.byte_address);
            size_r  <= ctl_run ? 4'd1 : in_data.access_bytes;
            wdata_r <= ctl_run ? {56'd0, low_byte & CTL_MASK} : in_data.write_data;
            if (in_err) begin
              state_r <= ST_FIN;
            end else if (in_data.opcode == OP_READ) begin
              state_r <= ST_READ;
            end else if (ctl_hit) begin
              state_r <= ST_RMW_RD;
              if (low_byte[CTL_RESET_BIT]) begin
                kind_r <= K_CTL_RST;
                tgt_r  <= ADDR_W'(in_data.byte_address - CH_CTL_OFS);
              end else begin
                kind_r <= K_CTL_RUN;
                tgt_r  <= ADDR_W'(in_data.byte_address - CH_CTL_TO_STAT);
              end
            end else if (stat_hit) begin
              kind_r  <= K_STAT;
              tgt_r   <= ADDR_W'(in_data.byte_address);
              state_r <= ST_RMW_RD;
            end else if (glob_hit) begin
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_WRITE;
            end
          end
        end
        ST_READ: begin
          // Capture the byte issued in the previous cycle.
          if (cnt_r != 4'd0) begin
            rdata_r[{cap_idx, 3'b000} +: 8] <= ram_q;
          end
          if (cnt_r == size_r) begin
            state_r <= ST_FIN;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_WRITE: begin
          if (cnt_r == 4'(size_r - 4'd1)) begin
            state_r <= ST_FIN;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_RMW_RD: begin
          state_r <= ST_RMW_WR;
        end
        ST_RMW_WR: begin
          cnt_r <= '0;
          unique case (kind_r)
            K_STAT:    state_r <= ST_FIN;
            K_CTL_RUN: state_r <= ST_WRITE;
            K_CTL_RST: state_r <= ST_SWEEP;
            default:   state_r <= ST_FIN;
          endcase
        end
        ST_SWEEP: begin
          if (cnt_r == CH_LAST_IDX) begin
            state_r <= ST_FIN;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_FIN: begin
          // Hold until the output register is free.
          if (out_free) begin
            out_r.read_data    <= rdata_r;
            out_r.access_error <= err_r;
            out_valid_r        <= 1'b1;
            state_r            <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // No result may appear before the power-up pass is through.
  `AC97BM_ASSERT_SAME(a_no_out_in_clear, state_r == ST_CLEAR, !out_valid_r)
  // A rejected beat goes straight to the finish step.
  `AC97BM_ASSERT_NEXT(a_err_to_fin, in_fire && in_err, state_r == ST_FIN && err_r)
  // A rejected access never carries data.
  `AC97BM_ASSERT_SAME(a_err_zero_data, out_valid_r && out_r.access_error,
                      out_r.read_data == 64'd0)
  // A channel reset sweep stays inside its twelve bytes.
  `AC97BM_ASSERT_SAME(a_sweep_bound, state_r == ST_SWEEP, cnt_r <= CH_LAST_IDX)

endmodule

/* tb/ac97_bus_master_register_file_top_tb.sv */
// Testbench for the AC'97 bus-master register file, checked against a byte shadow.
`timescale 1ns / 1ps
module ac97_bus_master_register_file_top_tb
  import ac97bm_pkg::*;
();

  // Give up when no beat moves on either channel for this many cycles. Cover the
  // power-up load of the whole store plus the long receiver hold-off, several times over.
  localparam int STUCK_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = 40;
  localparam int PHASE_ACCESSES = 292;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  ac97_bus_master_register_file_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Byte image of the register space, updated in the order accesses are accepted.
  logic [7:0] shadow_regs [REG_BYTES];

  in_item_t  access_q [$];   // accesses waiting to be offered
  out_item_t response_q [$]; // predicted responses, oldest first

  int accesses_queued;
  int accesses_taken;
  int responses_checked;
  int mismatches;
  int n_reads, n_writes, n_rejects, n_chan_resets, n_status_clears, n_global_dropped;

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_request;
  int  hold_left;
  bit  beat_taken;
  int  quiet_cycles;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s on response %0d: got %h, want %h",
             what, responses_checked, got, want);
    mismatches++;
  endtask

  // Power-up image: all zero except codec ready and each channel's halted status.
  task automatic reset_shadow();
    for (int k = 0; k < REG_BYTES; k++) begin
      shadow_regs[k] = 8'h00;
    end
    shadow_regs[CODEC_READY] = 8'h01;
    for (int c = 0; c < CH_COUNT; c++) begin
      shadow_regs[CH_BASE[c] + CH_STAT_OFS] = STAT_HALT;
    end
  endtask

  // Apply one accepted access to the shadow and queue the response it must produce.
  task automatic predict_access(input in_item_t acc);
    out_item_t  rsp;
    int         addr;
    int         len;
    int         base;
    logic [7:0] low_byte;
    logic [7:0] kept_ctl;
    bit         handled;
    rsp      = '0;
    addr     = int'(acc.byte_address);
    len      = int'(acc.access_bytes);
    low_byte = acc.write_data[7:0];
    handled  = 1'b0;
    if (len == 0 || len > 8 || addr + len > REG_BYTES) begin
      // Reject: no state change, error flag, data zero.
      rsp.access_error = 1'b1;
      n_rejects++;
    end else if (acc.opcode == OP_WRITE) begin
      n_writes++;
      for (int c = 0; c < CH_COUNT && !handled; c++) begin
        base = int'(CH_BASE[c]);
        if (addr == base + int'(CH_CTL_OFS) && len == 1) begin
          handled = 1'b1;
          if (low_byte[CTL_RESET_BIT]) begin
            // Channel reset: wipe the channel, halt it, keep the sticky control bits.
            kept_ctl = shadow_regs[base + int'(CH_CTL_OFS)] & CTL_KEEP;
            for (int k = 0; k <= int'(CH_LAST_IDX); k++) begin
              shadow_regs[base + k] = 8'h00;
            end
            shadow_regs[base + int'(CH_STAT_OFS)] = STAT_HALT;
            shadow_regs[base + int'(CH_CTL_OFS)]  = kept_ctl;
            n_chan_resets++;
          end else begin
            shadow_regs[addr] = low_byte & CTL_MASK;
            if (low_byte[CTL_RUN_BIT]) begin
              shadow_regs[base + int'(CH_STAT_OFS)] &= ~STAT_HALT;
            end else begin
              shadow_regs[base + int'(CH_STAT_OFS)] |= STAT_HALT;
            end
          end
        end else if (addr == base + int'(CH_STAT_OFS) && (len == 1 || len == 2)) begin
          // Write-one-to-clear on the status byte alone; the second byte is dropped.
          handled = 1'b1;
          shadow_regs[addr] &= ~(low_byte & STAT_W1C);
          n_status_clears++;
        end
      end
      if (!handled && addr == int'(GLOBAL_STATUS) && len == 4) begin
        handled = 1'b1;
        n_global_dropped++;
      end
      if (!handled) begin
        for (int k = 0; k < len; k++) begin
          shadow_regs[addr + k] = acc.write_data[8*k +: 8];
        end
      end
    end else begin
      n_reads++;
      for (int k = 0; k < len; k++) begin
        rsp.read_data[8*k +: 8] = shadow_regs[addr + k];
      end
    end
    response_q.push_back(rsp);
  endtask

  task automatic queue_access(input logic op, input int addr, input int len,
                              input logic [63:0] wdata);
    in_item_t acc;
    acc.opcode       = op;
    acc.byte_address = 12'(addr);
    acc.access_bytes = 4'(len);
    acc.write_data   = wdata;
    access_q.push_back(acc);
    accesses_queued++;
  endtask

  // Bias toward the channel and global status registers, where the special rules live.
  function automatic in_item_t random_access();
    in_item_t acc;
    int       pick;
    int       base;
    acc.opcode       = 1'($urandom_range(0, 1));
    acc.write_data   = {$urandom, $urandom};
    acc.access_bytes = 4'($urandom_range(1, 8));
    base = int'(CH_BASE[$urandom_range(0, CH_COUNT - 1)]);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      acc.byte_address = 12'(base + int'(CH_CTL_OFS));
      if ($urandom_range(0, 9) < 7) acc.access_bytes = 4'd1;
      if ($urandom_range(0, 9) < 8) acc.opcode = OP_WRITE;
    end else if (pick < 42) begin
      acc.byte_address = 12'(base + int'(CH_STAT_OFS));
      if ($urandom_range(0, 9) < 7) acc.access_bytes = 4'($urandom_range(1, 2));
    end else if (pick < 50) begin
      acc.byte_address = GLOBAL_STATUS;
      if ($urandom_range(0, 1) == 1) acc.access_bytes = 4'd4;
    end else if (pick < 72) begin
      acc.byte_address = 12'(base + $urandom_range(0, int'(CH_LAST_IDX)));
    end else if (pick < 82) begin
      // Hug the top of the space so some accesses run past the end.
      acc.byte_address = 12'(REG_BYTES - $urandom_range(1, 12));
    end else if (pick < 93) begin
      acc.byte_address = 12'($urandom_range(0, REG_BYTES - 1));
    end else begin
      acc.byte_address = 12'($urandom_range(0, REG_BYTES - 1));
      acc.access_bytes = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
    end
    return acc;
  endfunction

  task automatic queue_random(input int count);
    for (int k = 0; k < count; k++) begin
      access_q.push_back(random_access());
      accesses_queued++;
    end
  endtask

  // Wait until every queued access is taken and every response is back.
  task automatic drain();
    while (accesses_taken != accesses_queued || response_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Driver: offer a beat at the falling edge; hold it until the rising edge takes it.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      beat_taken = 1'b0;
      if (access_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data  <= access_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Capture accepted input beats and run them through the shadow.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_access(in_data);
      accesses_taken++;
      beat_taken = 1'b1;
    end
  end

  // Receiver: random stalls, or a long hold-off when asked, counted here.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: check each response beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (response_q.size() == 0) begin
        report_mismatch("response with no access pending", out_data.read_data, 64'h0);
      end else begin
        if (out_data.read_data !== response_q[0].read_data) begin
          report_mismatch("read_data", out_data.read_data, response_q[0].read_data);
        end
        if (out_data.access_error !== response_q[0].access_error) begin
          report_mismatch("access_error", 64'(out_data.access_error),
                          64'(response_q[0].access_error));
        end
        void'(response_q.pop_front());
      end
      responses_checked++;
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STUCK_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d responses outstanding",
                 quiet_cycles, response_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    send_idle_pct = 19;
    recv_idle_pct = 56;
    reset_shadow();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: power-up values, space edges, bad sizes and every channel rule.
    queue_access(OP_READ,  CODEC_READY, 1, 64'h0);
    queue_access(OP_READ,  CH_BASE[0], 8, 64'h0);
    queue_access(OP_WRITE, 0, 8, '1);
    queue_access(OP_READ,  0, 8, 64'h0);
    queue_access(OP_WRITE, REG_BYTES - 1, 1, 64'hFF);
    queue_access(OP_READ,  REG_BYTES - 8, 8, 64'h0);
    queue_access(OP_READ,  REG_BYTES - 1, 2, 64'h0);
    queue_access(OP_WRITE, 16, 0, '1);
    queue_access(OP_READ,  16, 9, 64'h0);
    queue_access(OP_WRITE, 16, 15, '1);
    // Run a channel, then force status bits on with a plain dword and clear them.
    queue_access(OP_WRITE, CH_BASE[1] + CH_CTL_OFS, 1, 64'hE1);
    queue_access(OP_WRITE, CH_BASE[1] + CH_STAT_OFS, 4, 64'hFFFF_FFFF);
    queue_access(OP_WRITE, CH_BASE[1] + CH_STAT_OFS, 1, 64'h0C);
    queue_access(OP_WRITE, CH_BASE[1] + CH_STAT_OFS, 2, 64'hFF10);
    queue_access(OP_READ,  CH_BASE[1] + 4, 8, 64'h0);
    // Fill a channel plainly, then reset it through its control byte.
    queue_access(OP_WRITE, CH_BASE[2], 8, '1);
    queue_access(OP_WRITE, CH_BASE[2] + 8, 4, 64'hFFFF_FFFF);
    queue_access(OP_WRITE, CH_BASE[2] + CH_CTL_OFS, 1, 64'h02);
    queue_access(OP_READ,  CH_BASE[2], 8, 64'h0);
    queue_access(OP_READ,  CH_BASE[2] + 8, 4, 64'h0);
    queue_access(OP_WRITE, CH_BASE[3] + CH_CTL_OFS, 1, 64'h00);
    queue_access(OP_WRITE, CH_BASE[3] + CH_CTL_OFS, 2, 64'hFFFF);
    queue_access(OP_WRITE, GLOBAL_STATUS, 4, '1);
    queue_access(OP_WRITE, GLOBAL_STATUS, 2, 64'hABCD);
    queue_access(OP_READ,  GLOBAL_STATUS, 4, 64'h0);
    drain();

    queue_random(PHASE_ACCESSES);
    drain();

    send_idle_pct = 56;
    recv_idle_pct = 19;
    queue_random(PHASE_ACCESSES);
    drain();

    // No idling; start with a long receiver hold-off so the block backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(PHASE_ACCESSES);
    hold_request = 1'b1;
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d accesses: %0d reads, %0d writes, %0d rejected; %0d responses checked",
             accesses_taken, n_reads, n_writes, n_rejects, responses_checked);
    $display("Channel resets %0d, status clears %0d, dropped global status writes %0d",
             n_chan_resets, n_status_clears, n_global_dropped);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ac97bm_pkg.sv
rtl/ac97bm_ram.sv
rtl/ac97_bus_master_register_file_top.sv
tb/ac97_bus_master_register_file_top_tb.sv
